[rtl/core/looped_cubic_bezier_envelope_top_assert.svh]
// Assertion macros for the looped cubic Bezier envelope top level.
`ifndef LOOPED_CUBIC_BEZIER_ENVELOPE_TOP_ASSERT_SVH
`define LOOPED_CUBIC_BEZIER_ENVELOPE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCBE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcbe: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LCBE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcbe: next-cycle check failed");

`endif

[rtl/core/lcbe_pkg.sv]
// Shared types, constants and tables of the looped cubic Bezier envelope.
`timescale 1ns / 1ps
package lcbe_pkg;

  localparam int DURATION_WIDTH_DEF = 16;
  localparam int VALUE_WIDTH_DEF    = 16;
  localparam int FRACTION_BITS_DEF  = 16;

  localparam int DELTA_W    = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_SEG    = 4;
  localparam int NUM_CTRL   = 5;
  localparam int NUM_BLEND  = 6;
  // Wide enough for the longest iteration count at the default parameter values.
  localparam int CNT_W      = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DUR_FIRST  = 3'd0,
    REG_DUR_SECOND = 3'd1,
    REG_VALUE_ONE  = 3'd2,
    REG_VALUE_TWO  = 3'd3,
    REG_VALUE_THR  = 3'd4,
    REG_VALUE_FOUR = 3'd5,
    REG_VALUE_FIVE = 3'd6
  } lcbe_cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEEK,
    ST_WRAP,
    ST_WCHK,
    ST_MDEC,
    ST_MOD,
    ST_MINC,
    ST_TSUB,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } lcbe_state_t;

  typedef struct packed {
    lcbe_state_t       state;
    logic [CNT_W-1:0]  cnt;
    logic              item_take;
    logic              out_load;
  } lcbe_ctrl_t;

  typedef struct packed {
    logic unit_neg;
    logic unit_zero;
    logic seg_last;
  } lcbe_status_t;

  // Width of the elapsed time: the period plus one full delta must fit.
  function automatic int elapsed_w(input int dw);
    int base;
    base = (dw + 2 > DELTA_W) ? dw + 2 : DELTA_W;
    return base + 1;
  endfunction

  // Control point j of segment seg, as an index into value_one..value_five.
  function automatic logic [2:0] ctrl_point(input logic [1:0] seg, input logic [1:0] j);
    logic [2:0] idx;
    case ({seg, j})
      4'b00_00, 4'b00_01: idx = 3'd0;
      4'b00_10:           idx = 3'd1;
      4'b00_11:           idx = 3'd2;
      4'b01_00:           idx = 3'd2;
      4'b01_01:           idx = 3'd3;
      4'b01_10, 4'b01_11: idx = 3'd4;
      4'b10_00, 4'b10_01: idx = 3'd4;
      4'b10_10:           idx = 3'd3;
      4'b10_11:           idx = 3'd2;
      4'b11_00:           idx = 3'd2;
      4'b11_01:           idx = 3'd1;
      default:            idx = 3'd0;
    endcase
    return idx;
  endfunction

  // Lower point of the blend done while the countdown stands at cnt.
  // The six steps run q0,q1,q2 then r0,r1 then y, all in place.
  function automatic logic [1:0] blend_first(input logic [CNT_W-1:0] cnt);
    logic [1:0] idx;
    case (cnt)
      5'd4:    idx = 2'd1;
      5'd3:    idx = 2'd2;
      5'd1:    idx = 2'd1;
      default: idx = 2'd0;
    endcase
    return idx;
  endfunction

endpackage

[rtl/core/lcbe_ctrl.sv]
// Sequencer that steps the shared unit through seek, wrap, reduce, divide and blend.
`timescale 1ns / 1ps
module lcbe_ctrl import lcbe_pkg::*; #(
  parameter int DURATION_WIDTH = DURATION_WIDTH_DEF,
  parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         out_free,
  input  lcbe_status_t status,
  output lcbe_ctrl_t   ctrl
);

  localparam int EW = elapsed_w(DURATION_WIDTH);

  lcbe_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    in_ready       = 1'b0;
    ctrl.item_take = 1'b0;
    ctrl.out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          ctrl.item_take = 1'b1;
          state_nxt      = ST_SEEK;
        end
      end
      ST_SEEK: begin
        if (status.unit_neg) begin
          if (status.seg_last) state_nxt = ST_WRAP;
        end else begin
          state_nxt = ST_TSUB;
        end
      end
      ST_WRAP: state_nxt = ST_WCHK;
      ST_WCHK: begin
        state_nxt = status.unit_neg ? ST_MDEC : ST_SEEK;
      end
      ST_MDEC: begin
        cnt_nxt   = CNT_W'(EW - 1);
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (cnt_r == '0) state_nxt = ST_MINC;
        else cnt_nxt = cnt_r - 1'b1;
      end
      ST_MINC: state_nxt = ST_SEEK;
      ST_TSUB: begin
        if (status.unit_neg || status.unit_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt   = CNT_W'(FRACTION_BITS);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r == '0) begin
          cnt_nxt   = CNT_W'(NUM_BLEND - 1);
          state_nxt = ST_MUL;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_MUL: state_nxt = ST_ADD;
      ST_ADD: begin
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ctrl.out_load = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    ctrl.state = state_r;
    ctrl.cnt   = cnt_r;
  end

endmodule

[rtl/core/lcbe_dp.sv]
// Datapath: time and segment state, shared subtractor and the blend multiplier.
`timescale 1ns / 1ps
module lcbe_dp import lcbe_pkg::*; #(
  parameter int DURATION_WIDTH = DURATION_WIDTH_DEF,
  parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lcbe_ctrl_t             ctrl,
  input  logic [DELTA_W-1:0]     in_delta,
  input  logic [CFG_DATA_W-1:0]  dur_first,
  input  logic [CFG_DATA_W-1:0]  dur_second,
  input  logic [VALUE_WIDTH-1:0] val_i [NUM_CTRL],
  output lcbe_status_t           status,
  output logic [VALUE_WIDTH-1:0] curve,
  output logic [1:0]             seg
);

  localparam int DW  = DURATION_WIDTH;
  localparam int VW  = VALUE_WIDTH;
  localparam int FB  = FRACTION_BITS;
  localparam int EW  = elapsed_w(DW);
  localparam int PW  = DW + 2;
  localparam int UW  = EW + 1;
  localparam int PRW = VW + FB + 3;

  logic [EW-1:0]        elapsed_r;
  logic [1:0]           seg_r;
  logic [EW-1:0]        rem_r;
  logic [EW-1:0]        shreg_r;
  logic [FB:0]          quo_r;
  logic signed [PRW-1:0] prod_r;
  logic [VW-1:0]        pt_r [4];

  logic [63:0]          pair_lo, pair_hi;
  logic [DW-1:0]        dfield [NUM_SEG];
  logic [PW-1:0]        dur [NUM_SEG];
  logic [PW-1:0]        bound [NUM_SEG+1];
  logic [PW-1:0]        dur_sel, start_sel, end_sel, period;
  logic [2:0]           seg_nx;
  logic [UW-1:0]        op_a, op_b, diff;
  logic [EW-1:0]        cand;
  logic [1:0]           ai, bi;
  logic signed [VW:0]   dv;
  logic signed [PRW-1:0] prod_nxt, step_q, sum_v;

  // Segment durations (zero counts as one) and the running boundaries.
  assign pair_lo = {32'd0, dur_first};
  assign pair_hi = {32'd0, dur_second};

  always_comb begin
    for (int k = 0; k < NUM_SEG; k++) begin
      dfield[k] = (k < 2) ? pair_lo[(k % 2) * DW +: DW] : pair_hi[(k % 2) * DW +: DW];
      dur[k]    = (dfield[k] == '0) ? PW'(1) : PW'(dfield[k]);
    end
    bound[0] = '0;
    for (int k = 0; k < NUM_SEG; k++) begin
      bound[k+1] = bound[k] + dur[k];
    end
  end

  assign seg_nx    = {1'b0, seg_r} + 3'd1;
  assign dur_sel   = dur[seg_r];
  assign start_sel = bound[{1'b0, seg_r}];
  assign end_sel   = bound[seg_nx];
  assign period    = bound[NUM_SEG];
  assign cand      = {rem_r[EW-2:0], shreg_r[EW-1]};

  // Shared subtractor: every compare, reduce and divide step goes through it.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (ctrl.state)
      ST_SEEK: begin op_a = UW'(end_sel);   op_b = UW'(elapsed_r); end
      ST_WRAP: begin op_a = UW'(elapsed_r); op_b = UW'(period);    end
      ST_WCHK: begin op_a = UW'(period);    op_b = UW'(elapsed_r); end
      ST_MDEC: begin op_a = UW'(elapsed_r); op_b = UW'(1);         end
      ST_MOD:  begin op_a = UW'(cand);      op_b = UW'(period);    end
      ST_MINC: begin op_a = UW'(rem_r);     op_b = '1;             end
      ST_TSUB: begin op_a = UW'(elapsed_r); op_b = UW'(start_sel); end
      ST_DIV:  begin op_a = UW'(rem_r);     op_b = UW'(dur_sel);   end
      default: begin op_a = '0;             op_b = '0;             end
    endcase
    diff = op_a - op_b;
  end

  assign status.unit_neg  = diff[UW-1];
  assign status.unit_zero = (diff == '0);
  assign status.seg_last  = (seg_r == 2'd3);

  // Blend unit: a + floor((b - a) * t / 2^FB).
  assign ai       = blend_first(ctrl.cnt);
  assign bi       = ai + 2'd1;
  assign dv       = $signed({pt_r[bi][VW-1], pt_r[bi]}) - $signed({pt_r[ai][VW-1], pt_r[ai]});
  assign prod_nxt = PRW'(dv) * PRW'($signed({1'b0, quo_r}));
  assign step_q   = prod_r >>> FB;
  assign sum_v    = PRW'($signed(pt_r[ai])) + step_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
      seg_r     <= '0;
    end else begin
      case (ctrl.state)
        ST_IDLE: if (ctrl.item_take) elapsed_r <= elapsed_r + EW'(in_delta);
        ST_SEEK: if (status.unit_neg) seg_r <= seg_r + 2'd1;
        ST_WRAP: elapsed_r <= diff[EW-1:0];
        ST_MINC: elapsed_r <= diff[EW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.state)
      ST_MDEC: begin
        shreg_r <= diff[EW-1:0];
        rem_r   <= '0;
      end
      ST_MOD: begin
        shreg_r <= {shreg_r[EW-2:0], 1'b0};
        rem_r   <= status.unit_neg ? cand : diff[EW-1:0];
      end
      ST_TSUB: begin
        rem_r <= diff[EW-1:0];
        quo_r <= '0;
        for (int j = 0; j < 4; j++) begin
          pt_r[j] <= val_i[ctrl_point(seg_r, 2'(j))];
        end
      end
      ST_DIV: begin
        if (status.unit_neg) begin
          rem_r <= {rem_r[EW-2:0], 1'b0};
          quo_r <= {quo_r[FB-1:0], 1'b0};
        end else begin
          rem_r <= {diff[EW-2:0], 1'b0};
          quo_r <= {quo_r[FB-1:0], 1'b1};
        end
      end
      ST_MUL:  prod_r   <= prod_nxt;
      ST_ADD:  pt_r[ai] <= sum_v[VW-1:0];
      default: ;
    endcase
  end

  assign curve = pt_r[0];
  assign seg   = seg_r;

endmodule

[rtl/core/looped_cubic_bezier_envelope_top.sv]
// Top level of the looping four-segment cubic Bezier envelope generator.
//
//   Channel  Direction  Handshake             Payload
//   in       sink       in_valid / in_ready   in_delta_time
//   out      source     out_valid / out_ready out_curve_value, out_segment_index
//   cfg      sink       cfg_wr_en (no wait)   cfg_index, cfg_wdata
//
// A transaction runs the seek, the bit-serial divider for t (FRACTION_BITS + 1 steps) and six
// blends on the single multiplier. Each segment boundary crossed adds a seek step, a pass
// through segment four a wrap and a check, and a time that spans more than one period a
// bit-serial reduction; a t of zero skips divide and blends. Reset is synchronous, active low,
// and clears control, time, config and output-valid state; input is taken only when idle.
// A finished result waits in the output register, so a stalled consumer holds only the last step.
`timescale 1ns / 1ps
module looped_cubic_bezier_envelope_top import lcbe_pkg::*; #(
  parameter int DURATION_WIDTH = DURATION_WIDTH_DEF,
  parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [DELTA_W-1:0]            in_delta_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] out_curve_value,
  output logic [1:0]                    out_segment_index,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  localparam logic [CFG_DATA_W-1:0] DUR_RESET = CFG_DATA_W'(65537);

  // Configuration registers. Both duration words reset so every segment lasts one tick.
  logic [CFG_DATA_W-1:0]  dur_first_r, dur_second_r;
  logic [VALUE_WIDTH-1:0] value_r [NUM_CTRL];

  // Output register, which frees the sequencer once a result is parked here.
  logic                   out_valid_r;
  logic [VALUE_WIDTH-1:0] out_curve_r;
  logic [1:0]             out_seg_r;

  lcbe_ctrl_t             ctrl_s;
  lcbe_status_t           status_s;
  logic [VALUE_WIDTH-1:0] curve_s;
  logic [1:0]             seg_s;
  logic                   out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_first_r  <= DUR_RESET;
      dur_second_r <= DUR_RESET;
      for (int i = 0; i < NUM_CTRL; i++) begin
        value_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      // Writes to an index past the last register are dropped.
      case (lcbe_cfg_reg_t'(cfg_index))
        REG_DUR_FIRST:  dur_first_r  <= cfg_wdata;
        REG_DUR_SECOND: dur_second_r <= cfg_wdata;
        REG_VALUE_ONE:  value_r[0]   <= cfg_wdata[VALUE_WIDTH-1:0];
        REG_VALUE_TWO:  value_r[1]   <= cfg_wdata[VALUE_WIDTH-1:0];
        REG_VALUE_THR:  value_r[2]   <= cfg_wdata[VALUE_WIDTH-1:0];
        REG_VALUE_FOUR: value_r[3]   <= cfg_wdata[VALUE_WIDTH-1:0];
        REG_VALUE_FIVE: value_r[4]   <= cfg_wdata[VALUE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // The sequencer may hand over a result when the output slot is empty or draining.
  assign out_free = !out_valid_r || out_ready;

  lcbe_ctrl #(
    .DURATION_WIDTH (DURATION_WIDTH),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .status   (status_s),
    .ctrl     (ctrl_s)
  );

  lcbe_dp #(
    .DURATION_WIDTH (DURATION_WIDTH),
    .VALUE_WIDTH    (VALUE_WIDTH),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl_s),
    .in_delta   (in_delta_time),
    .dur_first  (dur_first_r),
    .dur_second (dur_second_r),
    .val_i      (value_r),
    .status     (status_s),
    .curve      (curve_s),
    .seg        (seg_s)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl_s.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_s.out_load) begin
      out_curve_r <= curve_s;
      out_seg_r   <= seg_s;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_curve_value   = $signed(out_curve_r);
  assign out_segment_index = out_seg_r;

`include "looped_cubic_bezier_envelope_top_assert.svh"

  // Once a transaction is taken the sequencer is busy for at least the next cycle.
  `LCBE_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
  // A result is never written over one that the consumer has not yet taken.
  `LCBE_ASSERT_SAME(a_no_overwrite, ctrl_s.out_load, !out_valid_r || out_ready)
  // Every handed-over result shows up on the output channel in the next cycle.
  `LCBE_ASSERT_NEXT(a_result_shown, ctrl_s.out_load, out_valid)
  // Input is never taken while a result is still being handed over.
  `LCBE_ASSERT_SAME(a_take_excl_load, in_valid && in_ready, !ctrl_s.out_load)

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the looped cubic Bezier envelope top level.
`timescale 1ns / 1ps
module tb_top;
  import lcbe_pkg::*;

  // The block is built at its default widths, so the envelope math below uses them too.
  localparam int DUR_W = DURATION_WIDTH_DEF;
  localparam int LVL_W = VALUE_WIDTH_DEF;
  localparam int FRAC = FRACTION_BITS_DEF;

  // Register index that the block has no register for; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // Cycle limit for the whole run, set with a wide margin over a correct run.
  localparam int LIMIT_CYCLES = 600000;
  // Cycles allowed after the last result before a register write or the end of the run.
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 100;

  localparam int RANDOM_PHASES = 11;
  localparam int ITEMS_PER_PHASE = 103;

  // The receiver holds off once, after this many results, for this many cycles.
  localparam int HOLD_AFTER = 400;
  localparam int HOLD_CYCLES = 500;

  typedef struct packed {
    logic signed [LVL_W-1:0] curve;
    logic [1:0] seg;
  } envelope_sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [DELTA_W-1:0] in_delta_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [LVL_W-1:0] out_curve_value;
  logic [1:0] out_segment_index;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  looped_cubic_bezier_envelope_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_delta_time     (in_delta_time),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_curve_value   (out_curve_value),
    .out_segment_index (out_segment_index),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // 8 ns clock: four high, four low.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Envelope predictor. It keeps its own copy of the duration and level registers
  // and of the elapsed time and segment, and is stepped once per accepted tick.
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] dur_lo_pair = 32'h0001_0001;
  logic [CFG_DATA_W-1:0] dur_hi_pair = 32'h0001_0001;
  logic signed [LVL_W-1:0] ctrl_level [5] = '{default: '0};
  longint unsigned env_time = 0;
  int env_seg = 0;

  envelope_sample_t expected_samples [$];
  logic [DELTA_W-1:0] pending_ticks [$];

  int items_queued = 0;
  int ticks_accepted = 0;
  int samples_seen = 0;
  int error_count = 0;
  int settings_applied = 0;
  int cycle_count = 0;

  // Length of segment k; a zero field counts as one tick.
  function automatic longint unsigned seg_len(input int k);
    logic [CFG_DATA_W-1:0] pair;
    logic [DUR_W-1:0] d;
    pair = (k >= 2) ? dur_hi_pair : dur_lo_pair;
    d = (k % 2 == 1) ? pair[2*DUR_W-1:DUR_W] : pair[DUR_W-1:0];
    return (d == 0) ? 1 : longint'(d);
  endfunction

  function automatic longint unsigned seg_begin(input int k);
    longint unsigned acc;
    acc = 0;
    for (int i = 0; i < k && i < NUM_SEG; i++) acc += seg_len(i);
    return acc;
  endfunction

  // a + floor((b - a) * t / 2^FRAC); the arithmetic shift gives the floor for both signs.
  function automatic longint lerp_frac(input longint a, input longint b, input longint t);
    longint p;
    p = (b - a) * t;
    return a + (p >>> FRAC);
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_DUR_FIRST:  dur_lo_pair = data;
      REG_DUR_SECOND: dur_hi_pair = data;
      REG_VALUE_ONE:  ctrl_level[0] = data[LVL_W-1:0];
      REG_VALUE_TWO:  ctrl_level[1] = data[LVL_W-1:0];
      REG_VALUE_THR:  ctrl_level[2] = data[LVL_W-1:0];
      REG_VALUE_FOUR: ctrl_level[3] = data[LVL_W-1:0];
      REG_VALUE_FIVE: ctrl_level[4] = data[LVL_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the envelope by one tick and return the sample it produces.
  function automatic envelope_sample_t step_envelope(input logic [DELTA_W-1:0] dt);
    envelope_sample_t smp;
    longint unsigned period, st, dl, t;
    longint p0, p1, p2, p3, q0, q1, q2, r0, r1, y;
    period = seg_begin(NUM_SEG);
    env_time += dt;
    // Move on while the time lies strictly past the end of the current segment.
    while (env_time > seg_begin(env_seg) + seg_len(env_seg)) begin
      if (env_seg == NUM_SEG - 1) begin
        env_seg = 0;
        env_time -= period;
        // Several periods in one tick fold into (0, period].
        if (env_time > period) env_time = (env_time - 1) % period + 1;
      end else begin
        env_seg++;
      end
    end
    st = seg_begin(env_seg);
    dl = seg_len(env_seg);
    // A time before the segment start only follows a duration change; t clamps to zero.
    if (env_time <= st) t = 0;
    else t = ((env_time - st) << FRAC) / dl;
    if (t > (64'd1 << FRAC)) t = 64'd1 << FRAC;
    case (env_seg)
      0: begin
        p0 = ctrl_level[0]; p1 = ctrl_level[0]; p2 = ctrl_level[1]; p3 = ctrl_level[2];
      end
      1: begin
        p0 = ctrl_level[2]; p1 = ctrl_level[3]; p2 = ctrl_level[4]; p3 = ctrl_level[4];
      end
      2: begin
        p0 = ctrl_level[4]; p1 = ctrl_level[4]; p2 = ctrl_level[3]; p3 = ctrl_level[2];
      end
      default: begin
        p0 = ctrl_level[2]; p1 = ctrl_level[1]; p2 = ctrl_level[0]; p3 = ctrl_level[0];
      end
    endcase
    // de Casteljau: three blends, then two, then the last one.
    q0 = lerp_frac(p0, p1, longint'(t));
    q1 = lerp_frac(p1, p2, longint'(t));
    q2 = lerp_frac(p2, p3, longint'(t));
    r0 = lerp_frac(q0, q1, longint'(t));
    r1 = lerp_frac(q1, q2, longint'(t));
    y = lerp_frac(r0, r1, longint'(t));
    smp.curve = LVL_W'(y);
    smp.seg = 2'(env_seg);
    return smp;
  endfunction

  // ---------------------------------------------------------------------------
  // Cycle limit. A run that hangs is ended here as a failure.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results still due.", cycle_count,
               items_queued - samples_seen);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver. It offers ticks from the pending queue in bursts of random length with
  // random gaps between them. The predictor is stepped on each accepted transaction.
  // valid gets at most one nonblocking assignment per edge, so a burst never shows a
  // false low between back-to-back transactions.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin : tick_driver
    logic took;
    took = in_valid && in_ready;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (took) begin
        expected_samples.push_back(step_envelope(in_delta_time));
        ticks_accepted++;
      end
      if (!in_valid || took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          in_valid <= 1'b1;
          in_delta_time <= pending_ticks.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            // About a third of the bursts run straight into the next one.
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. It switches among always ready, a random half duty and one cycle in
  // three. Once, after a few hundred results, it holds off for a long stretch while
  // the driver keeps offering ticks, so the output register fills and the input stalls.
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left = 0;
  int phase_cnt = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin : sample_receiver
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      phase_cnt = (phase_cnt + 1) % 3;
      if (!hold_done && samples_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (phase_cnt == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Every accepted result transaction is compared, field by field, with
  // the oldest predicted sample.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sample_monitor
    envelope_sample_t want;
    if (rst_n && out_valid && out_ready) begin
      samples_seen++;
      if (expected_samples.size() == 0) begin
        $error("Result with no tick outstanding: curve_value %0d segment_index %0d",
               out_curve_value, out_segment_index);
        error_count++;
      end else begin
        want = expected_samples.pop_front();
        if (out_curve_value !== want.curve) begin
          $error("curve_value mismatch: expected %0d, actual %0d", want.curve,
                 out_curve_value);
          error_count++;
        end
        if (out_segment_index !== want.seg) begin
          $error("segment_index mismatch: expected %0d, actual %0d", want.seg,
                 out_segment_index);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequencing.
  // ---------------------------------------------------------------------------

  // One register write. The enable stays high across consecutive writes and is
  // dropped by end_writes, so each edge sees a single assignment.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    apply_reg(idx, data);
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_applied++;
  endtask

  task automatic queue_tick(input logic [DELTA_W-1:0] dt);
    pending_ticks.push_back(dt);
    items_queued++;
  endtask

  // Wait until every queued tick has produced its result, then let the block settle.
  task automatic drain();
    while (samples_seen < items_queued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [DUR_W-1:0] rand_duration();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return DUR_W'($urandom_range(1, 3));
      3: return DUR_W'($urandom);
      default: return DUR_W'($urandom_range(1, 400));
    endcase
  endfunction

  // Random register word for a level; the upper bits are noise the block must drop.
  function automatic logic [CFG_DATA_W-1:0] rand_level_word();
    logic [CFG_DATA_W-1:0] w;
    w = $urandom;
    case ($urandom_range(0, 5))
      0: w[LVL_W-1:0] = 16'h8000;
      1: w[LVL_W-1:0] = 16'h7FFF;
      default: ;
    endcase
    return w;
  endfunction

  // Tick sizes are scaled to the current period so most ticks cross a boundary or two.
  function automatic logic [DELTA_W-1:0] rand_tick(input longint unsigned period);
    longint unsigned cap;
    case ($urandom_range(0, 11))
      0: return '0;
      1: return '1;
      2: return DELTA_W'($urandom);
      3: begin
        cap = (period * 3 > 65535) ? 65535 : period * 3;
        return DELTA_W'($urandom_range(0, int'(cap)));
      end
      default: begin
        cap = period / 3 + 1;
        if (cap > 65535) cap = 65535;
        return DELTA_W'($urandom_range(0, int'(cap)));
      end
    endcase
  endfunction

  initial begin : stimulus
    logic [DUR_W-1:0] d0, d1, d2, d3;
    logic [CFG_DATA_W-1:0] lvl;
    longint unsigned period;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset values: every segment lasts one tick and every level is zero.
    // The largest tick folds through many periods at once.
    queue_tick(16'd0);
    queue_tick(16'd1);
    queue_tick(16'hFFFF);
    drain();

    // Unequal segments with levels at both extremes.
    write_reg(REG_DUR_FIRST, {16'd200, 16'd100});
    write_reg(REG_DUR_SECOND, {16'd400, 16'd300});
    write_reg(REG_VALUE_ONE, 32'h0000_8000);
    write_reg(REG_VALUE_TWO, 32'h0000_7FFF);
    write_reg(REG_VALUE_THR, 32'hFFFF_8000);
    write_reg(REG_VALUE_FOUR, 32'h1234_7FFF);
    write_reg(REG_VALUE_FIVE, 32'h0000_8000);
    end_writes();
    queue_tick(16'd50);
    queue_tick(16'd50);     // still short of the start of the last segment, no advance
    queue_tick(16'd1);
    queue_tick(16'd299);
    queue_tick(16'hFFFF);
    queue_tick(16'd0);
    drain();
    // Put the time into the last segment so the next duration change leaves it
    // ahead of the current time.
    queue_tick((env_time < 700) ? DELTA_W'(700 - env_time) : DELTA_W'(0));
    drain();

    // Longer segments: the last segment now starts far beyond the elapsed time, so t
    // is clamped to zero.
    write_reg(REG_DUR_FIRST, {16'd1000, 16'd1000});
    write_reg(REG_DUR_SECOND, {16'd1000, 16'd1000});
    end_writes();
    queue_tick(16'd0);
    queue_tick(16'd5);
    drain();

    // Zero duration fields count as one tick. The write to the unused index must be
    // dropped. The time is now well past the short period, so it folds many times.
    write_reg(REG_DUR_FIRST, {16'd0, 16'd3});
    write_reg(REG_DUR_SECOND, 32'h0000_0000);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    end_writes();
    queue_tick(16'd4);
    queue_tick(16'd7);
    queue_tick(16'd1);
    queue_tick(16'd0);
    drain();

    // Random phases. Each starts from a fresh setting written while the block is idle;
    // the elapsed time carries over, so duration changes also hit the clamp case.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == RANDOM_PHASES - 2) begin
        d0 = '1; d1 = '1; d2 = '1; d3 = '1;
      end else if (ph == RANDOM_PHASES - 1) begin
        d0 = '0; d1 = '0; d2 = '0; d3 = '0;
      end else begin
        d0 = rand_duration(); d1 = rand_duration();
        d2 = rand_duration(); d3 = rand_duration();
      end
      write_reg(REG_DUR_FIRST, {d1, d0});
      write_reg(REG_DUR_SECOND, {d3, d2});
      for (int r = REG_VALUE_ONE; r <= REG_VALUE_FIVE; r++) begin
        lvl = rand_level_word();
        // The long-segment phase runs with alternating extreme levels.
        if (ph == RANDOM_PHASES - 2) lvl[LVL_W-1:0] = (r % 2 == 0) ? 16'h8000 : 16'h7FFF;
        write_reg(CFG_IDX_W'(r), lvl);
      end
      if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, $urandom);
      end_writes();
      period = seg_begin(NUM_SEG);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) queue_tick(rand_tick(period));
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_samples.size() != 0) begin
      $error("%0d predicted samples never arrived", expected_samples.size());
      error_count++;
    end

    $display("Envelope run: %0d ticks sent over %0d register settings, %0d samples compared.",
             ticks_accepted, settings_applied, samples_seen);
    $display("Errors found: %0d.", error_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
